// ===== design/bracket_balance_checker_top_defines.svh =====
// Assertion helpers used by the stack engine RTL (bbc_back).
`ifndef BRACKET_BALANCE_CHECKER_TOP_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bbc_pkg.sv =====
package bbc_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int CHAR_W        = 8;
   localparam int ERR_W         = 3;
   localparam int KIND_W        = 2;
   localparam int QUEUE_DEPTH   = 2;

   // Classified operation codes
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_OPEN  = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;
   localparam logic [1:0] OP_BAD   = 2'd3;

   // Result error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_MISMATCH = 3'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd2;
   localparam logic [ERR_W-1:0] ERR_UNCLOSED = 3'd3;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;
   localparam logic [ERR_W-1:0] ERR_BADBYTE  = 3'd5;

   typedef struct packed {
      logic              last;
      logic [1:0]        op;
      logic [KIND_W-1:0] kind;
   } bbc_op_type;

endpackage

// ===== design/bbc_req_if.sv =====
interface bbc_req_if;
   logic                      valid;
   logic                      ready;
   logic                      has_char;
   logic [bbc_pkg::CHAR_W-1:0] char_code;
   logic                      last;

   modport source (output valid, output has_char, output char_code, output last,
                   input ready);
   modport sink   (input valid, input has_char, input char_code, input last,
                   output ready);
endinterface

// ===== design/bbc_rsp_if.sv =====
interface bbc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      is_balanced;
   logic [bbc_pkg::ERR_W-1:0] error_kind;

   modport source (output valid, output is_balanced, output error_kind, input ready);
   modport sink   (input valid, input is_balanced, input error_kind, output ready);
endinterface

// ===== design/bbc_front.sv =====
module bbc_front (
   bbc_req_if.sink            req_chan,
   output logic               op_valid,
   output bbc_pkg::bbc_op_type op,
   input  logic               op_ready
);
   import bbc_pkg::*;

   localparam logic [CHAR_W-1:0] CH_PAREN_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_PAREN_CLOSE = 8'h29;
   localparam logic [CHAR_W-1:0] CH_BRACK_OPEN  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_BRACK_CLOSE = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_BRACE_OPEN  = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_BRACE_CLOSE = 8'h7D;

   logic [1:0]        cls_op;
   logic [KIND_W-1:0] cls_kind;

   always_comb begin
      cls_op   = OP_BAD;
      cls_kind = '0;
      unique case (req_chan.char_code)
         CH_PAREN_OPEN:  begin cls_op = OP_OPEN;  cls_kind = 2'd1; end
         CH_BRACK_OPEN:  begin cls_op = OP_OPEN;  cls_kind = 2'd2; end
         CH_BRACE_OPEN:  begin cls_op = OP_OPEN;  cls_kind = 2'd3; end
         CH_PAREN_CLOSE: begin cls_op = OP_CLOSE; cls_kind = 2'd1; end
         CH_BRACK_CLOSE: begin cls_op = OP_CLOSE; cls_kind = 2'd2; end
         CH_BRACE_CLOSE: begin cls_op = OP_CLOSE; cls_kind = 2'd3; end
         default:        begin cls_op = OP_BAD;   cls_kind = '0;   end
      endcase
   end

   // end-only transactions carry no byte
   assign op.op          = req_chan.has_char ? cls_op : OP_NONE;
   assign op.kind        = cls_kind;
   assign op.last        = req_chan.last;
   assign op_valid       = req_chan.valid;
   assign req_chan.ready = op_ready;

endmodule

// ===== design/bbc_queue.sv =====
module bbc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  bbc_pkg::bbc_op_type in_op,
   output logic                in_ready,
   output logic                out_valid,
   output bbc_pkg::bbc_op_type out_op,
   input  logic                out_ready
);
   import bbc_pkg::*;

   localparam int QPW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   bbc_op_type       entry_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff < QCW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_op    = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_op;
      end
   end

endmodule

// ===== design/bbc_back.sv =====
`include "bracket_balance_checker_top_defines.svh"

module bbc_back #(
   parameter int DEPTH = bbc_pkg::DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  bbc_pkg::bbc_op_type op,
   output logic                op_ready,
   bbc_rsp_if.source           rsp_chan
);
   import bbc_pkg::*;

   localparam int LW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // entries below the top; the top itself lives in top_ff
   logic [KIND_W-1:0] kind_mem [DEPTH];

   logic [LW-1:0]     level_ff, level_in;
   logic [KIND_W-1:0] top_ff, top_in;
   logic [KIND_W-1:0] below_ff;          // kind_mem[level_ff - 2], prefetched
   logic [ERR_W-1:0]  err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              is_balanced_ff;
   logic [ERR_W-1:0]  error_kind_ff;

   logic              op_take;
   logic              mem_we;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [LW-1:0]     level_post, level_m1, level_m2;
   logic [ERR_W-1:0]  err_post, code;

   assign op_ready = !op.last || !rsp_valid_ff || rsp_chan.ready;
   assign op_take  = op_valid && op_ready;
   assign level_m1 = level_ff - LW'(1);

   always_comb begin
      level_post = level_ff;
      top_in     = top_ff;
      err_post   = err_ff;
      mem_we     = 1'b0;
      if (op_take && (err_ff == ERR_NONE)) begin
         unique case (op.op)
            OP_NONE: begin
            end
            OP_BAD: begin
               err_post = ERR_BADBYTE;
            end
            OP_OPEN: begin
               if (level_ff == LW'(DEPTH)) begin
                  err_post = ERR_OVERFLOW;
               end else begin
                  mem_we     = (level_ff != '0);
                  top_in     = op.kind;
                  level_post = level_ff + LW'(1);
               end
            end
            OP_CLOSE: begin
               if (level_ff == '0) begin
                  err_post = ERR_EMPTY;
               end else if (top_ff != op.kind) begin
                  err_post = ERR_MISMATCH;
               end else begin
                  top_in     = below_ff;
                  level_post = level_m1;
               end
            end
            default: begin
            end
         endcase
      end

      code = err_post;
      if ((err_post == ERR_NONE) && (level_post != '0)) begin
         code = ERR_UNCLOSED;
      end

      level_in = level_post;
      err_in   = err_post;
      if (op_take && op.last) begin
         level_in = '0;
         err_in   = ERR_NONE;
      end

      if (op_take && op.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign wr_addr  = level_m1[AW-1:0];
   assign level_m2 = level_in - LW'(2);
   assign rd_addr  = level_m2[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (op_take && op.last) begin
         is_balanced_ff <= (code == ERR_NONE);
         error_kind_ff  <= code;
      end
   end

   // stack memory: one write, one registered read with write bypass
   always_ff @(posedge clock) begin
      if (mem_we) begin
         kind_mem[wr_addr] <= top_ff;
      end
      if (mem_we && (wr_addr == rd_addr)) begin
         below_ff <= top_ff;
      end else begin
         below_ff <= kind_mem[rd_addr];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.is_balanced = is_balanced_ff;
   assign rsp_chan.error_kind  = error_kind_ff;

   `BBC_ASSERT_NOW(a_level_bound, clock, reset, 1'b1, level_ff <= LW'(DEPTH), "stack level above depth")
   `BBC_ASSERT_NEXT(a_end_clears, clock, reset, op_take && op.last, (level_ff == '0) && (err_ff == ERR_NONE), "string end did not clear state")
   `BBC_ASSERT_NOW(a_rsp_consistent, clock, reset, rsp_valid_ff, is_balanced_ff == (error_kind_ff == ERR_NONE), "balanced flag disagrees with error code")

endmodule

// ===== design/bracket_balance_checker_top.sv =====
// Bracket balance checker. Takes one byte per request transaction and gives one response
// transaction per string, on the request that carries last: is_balanced, and error_kind
// (0 ok, 1 mismatch, 2 close on empty, 3 unclosed, 4 overflow, 5 bad byte). The first error
// of a string sticks and later bytes of that string are ignored. A request with has_char low
// carries no byte; with last high it ends the string (empty string case). The block sustains
// one request per clock unless a waiting response holds it: a classifier front end feeds
// a two-entry queue, and the stack engine behind it does push, pop and top compare with the
// top of stack in a register and the entry below it prefetched from a single-port-write,
// registered-read stack memory of DEPTH entries of 2 bits. Response valid is registered:
// it rises at the edge at which the stack engine takes the string's final request and holds
// until the response is taken. While a response waits, requests keep flowing until the final
// request of the next string reaches the stack engine; the queue then fills and the request
// side stalls. No clearing pass after reset: stack memory is only read below the current level.
module bracket_balance_checker_top #(
   parameter int DEPTH = bbc_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);
   import bbc_pkg::*;

   // front end -> queue
   logic       fe_valid;
   bbc_op_type fe_op;
   logic       fe_ready;

   // queue -> stack engine
   logic       q_valid;
   bbc_op_type q_op;
   logic       q_ready;

   // classify each byte into open / close / bad / none plus its 2-bit kind
   bbc_front u_front (
      .req_chan (req_chan),
      .op_valid (fe_valid),
      .op       (fe_op),
      .op_ready (fe_ready)
   );

   // short queue decouples the input side from a stalled response
   bbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_op     (fe_op),
      .in_ready  (fe_ready),
      .out_valid (q_valid),
      .out_op    (q_op),
      .out_ready (q_ready)
   );

   // stack engine and response register
   bbc_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (q_valid),
      .op       (q_op),
      .op_ready (q_ready),
      .rsp_chan (rsp_chan)
   );

endmodule
